@@ rtl/shsr_pkg.sv @@
// Package for the half-step stepper ramp sequencer: types, constants, coil table.
`timescale 1ns / 1ps
package shsr_pkg;

  // Storage widths
  localparam int unsigned POSITION_WIDTH = 32;
  localparam int unsigned DELAY_WIDTH    = 16;
  localparam int unsigned CFG_WIDTH      = 16;
  localparam int unsigned STEPS_WIDTH    = 32;
  localparam int unsigned BEAT_WIDTH     = 3;
  localparam int unsigned COIL_WIDTH     = 4;
  localparam int unsigned OUT_POS_WIDTH  = 32;
  localparam int unsigned TARGET_WIDTH   = 32;
  localparam int unsigned COUNT_WIDTH    = 31;
  // Signed distance width for absolute moves (one bit over the wider operand)
  localparam int unsigned DIST_WIDTH =
      ((POSITION_WIDTH > TARGET_WIDTH) ? POSITION_WIDTH : TARGET_WIDTH) + 1;

  // Register reset values
  localparam logic [CFG_WIDTH-1:0] GOAL_DELAY_RST  = CFG_WIDTH'(10);
  localparam logic [CFG_WIDTH-1:0] START_DELAY_RST = CFG_WIDTH'(100);

  // Command codes
  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_FWD      = 2'd1,
    FUNC_BWD      = 2'd2,
    FUNC_ABSOLUTE = 2'd3
  } func_e;

  // Register indexes
  typedef enum logic [0:0] {
    REG_GOAL_DELAY  = 1'b0,
    REG_START_DELAY = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]                     func;
    logic [COUNT_WIDTH-1:0]         step_count;
    logic signed [TARGET_WIDTH-1:0] target_position;
  } in_beat_t;

  typedef struct packed {
    logic [COIL_WIDTH-1:0]           coil_drive;
    logic signed [OUT_POS_WIDTH-1:0] position;
    logic                            moving;
    logic                            step_taken;
    logic                            command_rejected;
  } out_beat_t;

  // Half-step coil pattern for each beat
  function automatic logic [COIL_WIDTH-1:0] coil_of_beat(input logic [BEAT_WIDTH-1:0] b);
    logic [COIL_WIDTH-1:0] p;
    case (b)
      3'd0:    p = 4'h3;
      3'd1:    p = 4'h2;
      3'd2:    p = 4'h6;
      3'd3:    p = 4'h4;
      3'd4:    p = 4'hC;
      3'd5:    p = 4'h8;
      3'd6:    p = 4'h9;
      default: p = 4'h1;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/stepper_half_step_ramp_sequencer.sv @@
// Top level: half-step stepper sequencer with linear delay ramp.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries commands: a timer
//   tick, a relative forward or backward move, or an absolute move. Every beat
//   accepted yields exactly one result beat on the output channel
//   (out_valid_o / out_stall_i / out_data_o) with coil drive, position and flags.
//   The state update and the result are computed in the cycle of acceptance
//   and the result is registered. Throughput is one beat per cycle while
//   in_stall_o is low; the state registers feed each beat's update back to later beats.
//   The output register is backed by a one-entry skid register, so a command
//   is still taken while a result waits; in_stall_o rises only when both hold
//   results, and drops once the receiver takes one.
//   cfg_we_i / cfg_index_i / cfg_data_i write the cruise delay (index 0) and
//   start_delay (index 1); the user must write them only while idle, the block does not enforce it.
//   Reset: position, beat and ramp state clear, coils off, no move running,
//   cruise delay = 10 and start_delay = 100, both output slots empty.
module stepper_half_step_ramp_sequencer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  shsr_pkg::in_beat_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output shsr_pkg::out_beat_t   out_data_o,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i
);
  import shsr_pkg::*;

  // Configuration registers
  logic [CFG_WIDTH-1:0] goal_cfg_q, start_cfg_q;

  // Motion state
  logic [BEAT_WIDTH-1:0]     beat_q, beat_d;
  logic [POSITION_WIDTH-1:0] pos_q, pos_d;
  logic [STEPS_WIDTH-1:0]    steps_q, steps_d;
  logic                      backward_q, backward_d;
  logic [DELAY_WIDTH-1:0]    hold_q, hold_d;
  logic [DELAY_WIDTH-1:0]    ramp_q, ramp_d;
  logic                      busy_q, busy_d;
  logic [COIL_WIDTH-1:0]     coil_q, coil_d;

  // Output slot and skid slot
  out_beat_t out_q, skid_q, result;
  logic      out_valid_q, skid_valid_q;

  logic in_accept, out_take;
  logic stepped, rejected;

  // Delays masked to the delay width
  logic [DELAY_WIDTH+CFG_WIDTH-1:0] goal_ext, start_ext;
  logic [DELAY_WIDTH-1:0]           goal_dly, start_dly, ramp_init;

  // Absolute move distance
  logic signed [DIST_WIDTH-1:0] tgt_s, pos_s, delta;
  logic [DIST_WIDTH-1:0]        mag;
  logic [STEPS_WIDTH-1:0]       mag_sat;
  logic                         abs_fwd;

  // Move decode
  logic [STEPS_WIDTH-1:0] move_count;
  logic                   move_back, move_req;

  // Position as reported on 32 bits
  logic [POSITION_WIDTH+OUT_POS_WIDTH-1:0] pos_ext;

  assign in_accept = in_valid_i && !skid_valid_q;
  assign out_take  = out_valid_q && !out_stall_i;
  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign goal_ext  = {{DELAY_WIDTH{1'b0}}, goal_cfg_q};
  assign start_ext = {{DELAY_WIDTH{1'b0}}, start_cfg_q};
  assign goal_dly  = goal_ext[DELAY_WIDTH-1:0];
  assign start_dly = start_ext[DELAY_WIDTH-1:0];
  assign ramp_init = (start_dly >= goal_dly) ? start_dly : goal_dly;

  // Signed distance target - position, magnitude saturated to steps width
  assign tgt_s   = DIST_WIDTH'(in_data_i.target_position);
  assign pos_s   = DIST_WIDTH'($signed(pos_q));
  assign delta   = tgt_s - pos_s;
  assign abs_fwd = (delta > 0);
  assign mag     = abs_fwd ? delta : -delta;
  assign mag_sat = (mag > DIST_WIDTH'({STEPS_WIDTH{1'b1}})) ? {STEPS_WIDTH{1'b1}}
                                                            : mag[STEPS_WIDTH-1:0];

  // Move command decode
  always_comb begin
    case (func_e'(in_data_i.func))
      FUNC_FWD: begin
        move_count = STEPS_WIDTH'(in_data_i.step_count);
        move_back  = 1'b0;
      end
      FUNC_BWD: begin
        move_count = STEPS_WIDTH'(in_data_i.step_count);
        move_back  = 1'b1;
      end
      FUNC_ABSOLUTE: begin
        move_count = mag_sat;
        move_back  = !abs_fwd;
      end
      default: begin
        move_count = '0;
        move_back  = 1'b0;
      end
    endcase
  end

  assign move_req = (func_e'(in_data_i.func) != FUNC_TICK);

  // Next motion state for the incoming beat
  always_comb begin
    beat_d     = beat_q;
    pos_d      = pos_q;
    steps_d    = steps_q;
    backward_d = backward_q;
    hold_d     = hold_q;
    ramp_d     = ramp_q;
    busy_d     = busy_q;
    coil_d     = coil_q;
    stepped    = 1'b0;
    rejected   = 1'b0;
    if (!move_req) begin
      if (busy_q) begin
        if (hold_q > DELAY_WIDTH'(1)) begin
          hold_d = hold_q - DELAY_WIDTH'(1);
        end else if (steps_q == '0) begin
          // move done: release coils
          busy_d = 1'b0;
          hold_d = '0;
          coil_d = '0;
        end else begin
          if (backward_q) begin
            beat_d = beat_q - BEAT_WIDTH'(1);
            pos_d  = pos_q - POSITION_WIDTH'(1);
          end else begin
            beat_d = beat_q + BEAT_WIDTH'(1);
            pos_d  = pos_q + POSITION_WIDTH'(1);
          end
          coil_d  = coil_of_beat(beat_d);
          steps_d = steps_q - STEPS_WIDTH'(1);
          hold_d  = ramp_q;
          if (ramp_q > goal_dly) begin
            ramp_d = ramp_q - DELAY_WIDTH'(1);
          end
          stepped = 1'b1;
        end
      end
    end else if (busy_q) begin
      rejected = 1'b1;
    end else if (move_count != '0) begin
      steps_d    = move_count;
      backward_d = move_back;
      hold_d     = '0;
      ramp_d     = ramp_init;
      busy_d     = 1'b1;
    end
  end

  // Result beat
  assign pos_ext = {{OUT_POS_WIDTH{1'b0}}, pos_d};
  always_comb begin
    result.coil_drive       = busy_d ? coil_d : '0;
    result.position         = pos_ext[OUT_POS_WIDTH-1:0];
    result.moving           = busy_d;
    result.step_taken       = stepped;
    result.command_rejected = rejected;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_cfg_q  <= GOAL_DELAY_RST;
      start_cfg_q <= START_DELAY_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_GOAL_DELAY:  goal_cfg_q  <= cfg_data_i;
        REG_START_DELAY: start_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Motion state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q     <= '0;
      pos_q      <= '0;
      steps_q    <= '0;
      backward_q <= 1'b0;
      hold_q     <= '0;
      ramp_q     <= '0;
      busy_q     <= 1'b0;
      coil_q     <= '0;
    end else if (in_accept) begin
      beat_q     <= beat_d;
      pos_q      <= pos_d;
      steps_q    <= steps_d;
      backward_q <= backward_d;
      hold_q     <= hold_d;
      ramp_q     <= ramp_d;
      busy_q     <= busy_d;
      coil_q     <= coil_d;
    end
  end

  // Output register with skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload slots, no reset needed
  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_accept) begin
        out_q <= result;
      end
    end else if (in_accept) begin
      skid_q <= result;
    end
  end

  // Skid slot only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot full with output slot empty");

  // Idle means the hold counter is cleared
  a_idle_hold_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (hold_q == '0))
    else $error("hold counter nonzero while idle");

  // A step moves the position by exactly one
  a_step_moves_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && stepped) |=> ((pos_q == $past(pos_q) + POSITION_WIDTH'(1)) ||
                                (pos_q == $past(pos_q) - POSITION_WIDTH'(1))))
    else $error("step did not move position by one");

  // A rejected command leaves the move untouched
  a_reject_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && rejected) |=> (busy_q && $stable(steps_q) && $stable(pos_q)))
    else $error("rejected command changed motion state");

endmodule
